// ----- hw/rtl/qvr_pkg.sv -----
`timescale 1ns / 1ps

package qvr_pkg;

   typedef enum logic [1:0] {
      CSR_ROT_W = 2'd0,
      CSR_ROT_X = 2'd1,
      CSR_ROT_Y = 2'd2,
      CSR_ROT_Z = 2'd3
   } csr_index_type;

   localparam int NUM_PRODUCTS = 12;

endpackage

// ----- hw/rtl/qvr_fwd.sv -----
`timescale 1ns / 1ps

module qvr_fwd #(
   parameter int W = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic signed [W-1:0]   rot_w,
   input  logic signed [W-1:0]   rot_x,
   input  logic signed [W-1:0]   rot_y,
   input  logic signed [W-1:0]   rot_z,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic signed [W-1:0]   vec_x,
   input  logic signed [W-1:0]   vec_y,
   input  logic signed [W-1:0]   vec_z,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic signed [2*W:0]   p_w,
   output logic signed [2*W:0]   p_x,
   output logic signed [2*W:0]   p_y,
   output logic signed [2*W:0]   p_z
);
   import qvr_pkg::*;

   localparam int MW = 2 * W;
   localparam int PW = 2 * W + 1;

   logic                 va_ff, va_in;
   logic                 vb_ff, vb_in;
   logic                 ready_a, ready_b;
   logic signed [MW-1:0] prod_ff [NUM_PRODUCTS];
   logic signed [MW-1:0] prod_in [NUM_PRODUCTS];
   logic signed [PW-1:0] pw_ff, px_ff, py_ff, pz_ff;
   logic signed [PW-1:0] pw_in, px_in, py_in, pz_in;

   assign ready_b  = !vb_ff || out_ready;
   assign ready_a  = !va_ff || ready_b;
   assign in_ready = ready_a;

   always_comb begin
      va_in = ready_a ? in_valid : va_ff;
      vb_in = ready_b ? va_ff : vb_ff;
   end

   // q * (0, v): one product per term
   always_comb begin
      prod_in[0]  = MW'(rot_x) * MW'(vec_x);
      prod_in[1]  = MW'(rot_y) * MW'(vec_y);
      prod_in[2]  = MW'(rot_z) * MW'(vec_z);
      prod_in[3]  = MW'(rot_w) * MW'(vec_x);
      prod_in[4]  = MW'(rot_y) * MW'(vec_z);
      prod_in[5]  = MW'(rot_z) * MW'(vec_y);
      prod_in[6]  = MW'(rot_w) * MW'(vec_y);
      prod_in[7]  = MW'(rot_x) * MW'(vec_z);
      prod_in[8]  = MW'(rot_z) * MW'(vec_x);
      prod_in[9]  = MW'(rot_w) * MW'(vec_z);
      prod_in[10] = MW'(rot_x) * MW'(vec_y);
      prod_in[11] = MW'(rot_y) * MW'(vec_x);
   end

   always_comb begin
      pw_in = -PW'(prod_ff[0]) - PW'(prod_ff[1]) - PW'(prod_ff[2]);
      px_in =  PW'(prod_ff[3]) + PW'(prod_ff[4]) - PW'(prod_ff[5]);
      py_in =  PW'(prod_ff[6]) - PW'(prod_ff[7]) + PW'(prod_ff[8]);
      pz_in =  PW'(prod_ff[9]) + PW'(prod_ff[10]) - PW'(prod_ff[11]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         va_ff <= va_in;
         vb_ff <= vb_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_a && in_valid) begin
         prod_ff <= prod_in;
      end
      if (ready_b && va_ff) begin
         pw_ff <= pw_in;
         px_ff <= px_in;
         py_ff <= py_in;
         pz_ff <= pz_in;
      end
   end

   assign out_valid = vb_ff;
   assign p_w       = pw_ff;
   assign p_x       = px_ff;
   assign p_y       = py_ff;
   assign p_z       = pz_ff;

endmodule

// ----- hw/rtl/qvr_back.sv -----
`timescale 1ns / 1ps

module qvr_back #(
   parameter int W = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic signed [W-1:0]   rot_w,
   input  logic signed [W-1:0]   rot_x,
   input  logic signed [W-1:0]   rot_y,
   input  logic signed [W-1:0]   rot_z,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic signed [2*W:0]   p_w,
   input  logic signed [2*W:0]   p_x,
   input  logic signed [2*W:0]   p_y,
   input  logic signed [2*W:0]   p_z,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic signed [2*W+2:0] hi_x,
   output logic signed [2*W+2:0] hi_y,
   output logic signed [2*W+2:0] hi_z,
   output logic signed [2*W+2:0] lo_x,
   output logic signed [2*W+2:0] lo_y,
   output logic signed [2*W+2:0] lo_z
);
   import qvr_pkg::*;

   localparam int PW  = 2 * W + 1;
   localparam int LPW = 2 * W + 1;
   localparam int SW  = 2 * W + 3;
   localparam logic signed [SW-1:0] ROUND_HALF =
      {{(SW-2*W+2){1'b0}}, 1'b1, {(2*W-3){1'b0}}};

   logic                  vc_ff, vc_in;
   logic                  vd_ff, vd_in;
   logic                  ready_c, ready_d;
   logic signed [W:0]     pl_w, pl_x, pl_y, pl_z;
   logic signed [W:0]     ph_w, ph_x, ph_y, ph_z;
   logic signed [LPW-1:0] lo_ff [NUM_PRODUCTS];
   logic signed [LPW-1:0] lo_in [NUM_PRODUCTS];
   logic signed [LPW-1:0] hi_ff [NUM_PRODUCTS];
   logic signed [LPW-1:0] hi_in [NUM_PRODUCTS];
   logic signed [SW-1:0]  hx_ff, hy_ff, hz_ff, lx_ff, ly_ff, lz_ff;
   logic signed [SW-1:0]  hx_in, hy_in, hz_in, lx_in, ly_in, lz_in;

   assign ready_d  = !vd_ff || out_ready;
   assign ready_c  = !vc_ff || ready_d;
   assign in_ready = ready_c;

   always_comb begin
      vc_in = ready_c ? in_valid : vc_ff;
      vd_in = ready_d ? vc_ff : vd_ff;
   end

   // p split into an unsigned low half and a signed high half
   always_comb begin
      pl_w = $signed({1'b0, p_w[W-1:0]});
      pl_x = $signed({1'b0, p_x[W-1:0]});
      pl_y = $signed({1'b0, p_y[W-1:0]});
      pl_z = $signed({1'b0, p_z[W-1:0]});
      ph_w = $signed(p_w[PW-1:W]);
      ph_x = $signed(p_x[PW-1:W]);
      ph_y = $signed(p_y[PW-1:W]);
      ph_z = $signed(p_z[PW-1:W]);
   end

   // p * conj(q): x terms 0..3, y terms 4..7, z terms 8..11
   always_comb begin
      lo_in[0]  = LPW'(pl_w) * LPW'(rot_x);
      lo_in[1]  = LPW'(pl_x) * LPW'(rot_w);
      lo_in[2]  = LPW'(pl_y) * LPW'(rot_z);
      lo_in[3]  = LPW'(pl_z) * LPW'(rot_y);
      lo_in[4]  = LPW'(pl_w) * LPW'(rot_y);
      lo_in[5]  = LPW'(pl_x) * LPW'(rot_z);
      lo_in[6]  = LPW'(pl_y) * LPW'(rot_w);
      lo_in[7]  = LPW'(pl_z) * LPW'(rot_x);
      lo_in[8]  = LPW'(pl_w) * LPW'(rot_z);
      lo_in[9]  = LPW'(pl_x) * LPW'(rot_y);
      lo_in[10] = LPW'(pl_y) * LPW'(rot_x);
      lo_in[11] = LPW'(pl_z) * LPW'(rot_w);
      hi_in[0]  = LPW'(ph_w) * LPW'(rot_x);
      hi_in[1]  = LPW'(ph_x) * LPW'(rot_w);
      hi_in[2]  = LPW'(ph_y) * LPW'(rot_z);
      hi_in[3]  = LPW'(ph_z) * LPW'(rot_y);
      hi_in[4]  = LPW'(ph_w) * LPW'(rot_y);
      hi_in[5]  = LPW'(ph_x) * LPW'(rot_z);
      hi_in[6]  = LPW'(ph_y) * LPW'(rot_w);
      hi_in[7]  = LPW'(ph_z) * LPW'(rot_x);
      hi_in[8]  = LPW'(ph_w) * LPW'(rot_z);
      hi_in[9]  = LPW'(ph_x) * LPW'(rot_y);
      hi_in[10] = LPW'(ph_y) * LPW'(rot_x);
      hi_in[11] = LPW'(ph_z) * LPW'(rot_w);
   end

   // rounding half folded into the low sums
   always_comb begin
      lx_in = -SW'(lo_ff[0]) + SW'(lo_ff[1]) - SW'(lo_ff[2]) + SW'(lo_ff[3])
              + ROUND_HALF;
      ly_in = -SW'(lo_ff[4]) + SW'(lo_ff[5]) + SW'(lo_ff[6]) - SW'(lo_ff[7])
              + ROUND_HALF;
      lz_in = -SW'(lo_ff[8]) - SW'(lo_ff[9]) + SW'(lo_ff[10]) + SW'(lo_ff[11])
              + ROUND_HALF;
      hx_in = -SW'(hi_ff[0]) + SW'(hi_ff[1]) - SW'(hi_ff[2]) + SW'(hi_ff[3]);
      hy_in = -SW'(hi_ff[4]) + SW'(hi_ff[5]) + SW'(hi_ff[6]) - SW'(hi_ff[7]);
      hz_in = -SW'(hi_ff[8]) - SW'(hi_ff[9]) + SW'(hi_ff[10]) + SW'(hi_ff[11]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else begin
         vc_ff <= vc_in;
         vd_ff <= vd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_c && in_valid) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
      if (ready_d && vc_ff) begin
         lx_ff <= lx_in;
         ly_ff <= ly_in;
         lz_ff <= lz_in;
         hx_ff <= hx_in;
         hy_ff <= hy_in;
         hz_ff <= hz_in;
      end
   end

   assign out_valid = vd_ff;
   assign hi_x      = hx_ff;
   assign hi_y      = hy_ff;
   assign hi_z      = hz_ff;
   assign lo_x      = lx_ff;
   assign lo_y      = ly_ff;
   assign lo_z      = lz_ff;

endmodule

// ----- hw/rtl/qvr_round.sv -----
`timescale 1ns / 1ps

module qvr_round #(
   parameter int W = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic signed [2*W+2:0] hi_x,
   input  logic signed [2*W+2:0] hi_y,
   input  logic signed [2*W+2:0] hi_z,
   input  logic signed [2*W+2:0] lo_x,
   input  logic signed [2*W+2:0] lo_y,
   input  logic signed [2*W+2:0] lo_z,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic signed [W-1:0]   out_x,
   output logic signed [W-1:0]   out_y,
   output logic signed [W-1:0]   out_z,
   output logic                  clipped
);
   import qvr_pkg::*;

   localparam int RW  = 3 * W + 3;
   localparam int FS  = 2 * W - 2;
   localparam int SHW = RW - FS;
   localparam logic signed [W-1:0] OUT_MAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] OUT_MIN = {1'b1, {(W-1){1'b0}}};

   logic                  ve_ff, ve_in;
   logic                  vf_ff, vf_in;
   logic                  ready_e, ready_f;
   logic signed [RW-1:0]  rx, ry, rz;
   logic signed [SHW-1:0] shx_ff, shy_ff, shz_ff;
   logic signed [SHW-1:0] shx_in, shy_in, shz_in;
   logic                  sat_x, sat_y, sat_z;
   logic signed [W-1:0]   ox_ff, oy_ff, oz_ff;
   logic signed [W-1:0]   ox_in, oy_in, oz_in;
   logic                  clip_ff, clip_in;

   assign ready_f  = !vf_ff || out_ready;
   assign ready_e  = !ve_ff || ready_f;
   assign in_ready = ready_e;

   always_comb begin
      ve_in = ready_e ? in_valid : ve_ff;
      vf_in = ready_f ? ve_ff : vf_ff;
   end

   // join halves, then drop the fraction bits with a floor
   always_comb begin
      rx     = (RW'(hi_x) <<< W) + RW'(lo_x);
      ry     = (RW'(hi_y) <<< W) + RW'(lo_y);
      rz     = (RW'(hi_z) <<< W) + RW'(lo_z);
      shx_in = $signed(rx[RW-1:FS]);
      shy_in = $signed(ry[RW-1:FS]);
      shz_in = $signed(rz[RW-1:FS]);
   end

   always_comb begin
      sat_x   = !(&shx_ff[SHW-1:W-1]) && (|shx_ff[SHW-1:W-1]);
      sat_y   = !(&shy_ff[SHW-1:W-1]) && (|shy_ff[SHW-1:W-1]);
      sat_z   = !(&shz_ff[SHW-1:W-1]) && (|shz_ff[SHW-1:W-1]);
      ox_in   = sat_x ? (shx_ff[SHW-1] ? OUT_MIN : OUT_MAX) : shx_ff[W-1:0];
      oy_in   = sat_y ? (shy_ff[SHW-1] ? OUT_MIN : OUT_MAX) : shy_ff[W-1:0];
      oz_in   = sat_z ? (shz_ff[SHW-1] ? OUT_MIN : OUT_MAX) : shz_ff[W-1:0];
      clip_in = sat_x || sat_y || sat_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ve_ff <= 1'b0;
         vf_ff <= 1'b0;
      end else begin
         ve_ff <= ve_in;
         vf_ff <= vf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_e && in_valid) begin
         shx_ff <= shx_in;
         shy_ff <= shy_in;
         shz_ff <= shz_in;
      end
      if (ready_f && ve_ff) begin
         ox_ff   <= ox_in;
         oy_ff   <= oy_in;
         oz_ff   <= oz_in;
         clip_ff <= clip_in;
      end
   end

   assign out_valid = vf_ff;
   assign out_x     = ox_ff;
   assign out_y     = oy_ff;
   assign out_z     = oz_ff;
   assign clipped   = clip_ff;

endmodule

// ----- hw/rtl/quaternion_vector_rotate.sv -----
// throughput: one vector per cycle while rsp_ready is high; the six pipeline
// stages each hold one beat and a stage advances whenever the stage after it
// is empty or moving
// reset: synchronous, clears every stage valid bit and loads the quaternion
// registers with w at full scale and x, y, z at zero
`timescale 1ns / 1ps

module quaternion_vector_rotate #(
   parameter int DATA_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  qvr_pkg::csr_index_type        csr_index,
   input  logic [DATA_WIDTH-1:0]         csr_wdata,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [DATA_WIDTH-1:0]  req_vec_x,
   input  logic signed [DATA_WIDTH-1:0]  req_vec_y,
   input  logic signed [DATA_WIDTH-1:0]  req_vec_z,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [DATA_WIDTH-1:0]  rsp_out_x,
   output logic signed [DATA_WIDTH-1:0]  rsp_out_y,
   output logic signed [DATA_WIDTH-1:0]  rsp_out_z,
   output logic                          rsp_clipped
);
   import qvr_pkg::*;

   localparam int W = DATA_WIDTH;
   localparam logic signed [W-1:0] ROT_W_RESET = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] OUT_MAX     = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] OUT_MIN     = {1'b1, {(W-1){1'b0}}};

   logic signed [W-1:0]   rot_w_ff, rot_x_ff, rot_y_ff, rot_z_ff;
   logic                  fwd_valid, fwd_ready;
   logic signed [2*W:0]   p_w, p_x, p_y, p_z;
   logic                  back_valid, back_ready;
   logic signed [2*W+2:0] hi_x, hi_y, hi_z, lo_x, lo_y, lo_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_w_ff <= ROT_W_RESET;
         rot_x_ff <= '0;
         rot_y_ff <= '0;
         rot_z_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ROT_W: rot_w_ff <= csr_wdata;
            CSR_ROT_X: rot_x_ff <= csr_wdata;
            CSR_ROT_Y: rot_y_ff <= csr_wdata;
            CSR_ROT_Z: rot_z_ff <= csr_wdata;
            default:   rot_w_ff <= rot_w_ff;
         endcase
      end
   end

   qvr_fwd #(.W(W)) u_fwd (
      .clock     (clock),
      .reset     (reset),
      .rot_w     (rot_w_ff),
      .rot_x     (rot_x_ff),
      .rot_y     (rot_y_ff),
      .rot_z     (rot_z_ff),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .vec_x     (req_vec_x),
      .vec_y     (req_vec_y),
      .vec_z     (req_vec_z),
      .out_valid (fwd_valid),
      .out_ready (fwd_ready),
      .p_w       (p_w),
      .p_x       (p_x),
      .p_y       (p_y),
      .p_z       (p_z)
   );

   qvr_back #(.W(W)) u_back (
      .clock     (clock),
      .reset     (reset),
      .rot_w     (rot_w_ff),
      .rot_x     (rot_x_ff),
      .rot_y     (rot_y_ff),
      .rot_z     (rot_z_ff),
      .in_valid  (fwd_valid),
      .in_ready  (fwd_ready),
      .p_w       (p_w),
      .p_x       (p_x),
      .p_y       (p_y),
      .p_z       (p_z),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .hi_x      (hi_x),
      .hi_y      (hi_y),
      .hi_z      (hi_z),
      .lo_x      (lo_x),
      .lo_y      (lo_y),
      .lo_z      (lo_z)
   );

   qvr_round #(.W(W)) u_round (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (back_valid),
      .in_ready  (back_ready),
      .hi_x      (hi_x),
      .hi_y      (hi_y),
      .hi_z      (hi_z),
      .lo_x      (lo_x),
      .lo_y      (lo_y),
      .lo_z      (lo_z),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_x     (rsp_out_x),
      .out_y     (rsp_out_y),
      .out_z     (rsp_out_z),
      .clipped   (rsp_clipped)
   );

   // an empty or draining output stage lets every stage move
   a_ready_ripple: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("req_ready low while output stage can drain");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high straight after reset");

   a_clip_extreme: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_clipped) |->
         (rsp_out_x == OUT_MAX || rsp_out_x == OUT_MIN ||
          rsp_out_y == OUT_MAX || rsp_out_y == OUT_MIN ||
          rsp_out_z == OUT_MAX || rsp_out_z == OUT_MIN))
      else $error("clipped set with no component at a limit");

endmodule
